### hw/rtl/mmc_pkg.sv
package mmc_pkg;

    // Fixed field widths of the stream items and configuration registers.
    localparam int CMD_W     = 2;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 35;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // Default sizes handed to the top level.
    localparam int DEF_MAX_DIM      = 8;
    localparam int DEF_ELEMENT_BITS = 16;

    // Every dimension register comes out of reset at eight.
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Request kinds carried in tuser on the input stream.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_RUN     = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } t_cfg_reg;

    // Tag that travels with one multiply-accumulate term.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

### hw/rtl/matrix_multiply_core.sv
// Fixed-point matrix multiply, C = A * B, with signed Q8.8 elements.
// Input stream: each request carries a kind in s_tuser (write A element,
// write B element, or run). A write stores elem_value at
// (elem_row, elem_col); it produces no result. A run emits every element of
// C in row-major order on the output stream as an exact Q19.16 sum, with
// m_tlast high on the final element.
// Dimensions come from three registers on the write port (rows_a, inner_dim,
// cols_b); a value of zero counts as one and a value above MAX_DIM as MAX_DIM.
// One shared multiplier and accumulator do all the work. Each product element
// passes through term issue, the operand read, the product register and the
// accumulator, then a wait for the finished sum, and finally a load into the
// output register. After a run is accepted, s_tready stays low until the
// final element is loaded into the output register, so receiver stalls
// lengthen the wait.
// A receiver stall holds the output register; the sequencer waits with the
// next sum until the register is taken. Reset returns to idle, empties the
// output register and sets all dimensions to eight; stored elements are not
// cleared and must be written before a run reads them.
module matrix_multiply_core #(
    parameter int MAX_DIM      = mmc_pkg::DEF_MAX_DIM,
    parameter int ELEMENT_BITS = mmc_pkg::DEF_ELEMENT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [mmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmc_pkg::CFG_W-1:0]        i_cfg_data,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: elem_row [2:0], elem_col [5:3], elem_value [21:6], zeros above.
    input  logic [mmc_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: command [1:0].
    input  logic [mmc_pkg::CMD_W-1:0]        s_tuser,
    // Output stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: out_row [2:0], out_col [5:3], product_sum [40:6], zeros above.
    output logic [mmc_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tlast
);

    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int VEXT_W  = (ELEMENT_BITS > mmc_pkg::VALUE_W) ? ELEMENT_BITS
                                                               : mmc_pkg::VALUE_W;
    localparam int USED_W  = mmc_pkg::ROW_W + mmc_pkg::COL_W + mmc_pkg::SUM_W;

    logic [mmc_pkg::CFG_W-1:0]     r_rows_a;
    logic [mmc_pkg::CFG_W-1:0]     r_inner_dim;
    logic [mmc_pkg::CFG_W-1:0]     r_cols_b;

    logic                          s_accept;
    logic [mmc_pkg::ROW_W-1:0]     in_row;
    logic [mmc_pkg::COL_W-1:0]     in_col;
    logic signed [mmc_pkg::VALUE_W-1:0] in_value;
    logic signed [VEXT_W-1:0]      value_ext;
    logic                          in_range;
    logic                          we_a;
    logic                          we_b;
    logic                          start;
    logic [ADDR_W-1:0]             wr_addr;

    logic                          idle;
    mmc_pkg::t_mac_ctl             mac_ctl;
    logic [ADDR_W-1:0]             rd_a_addr;
    logic [ADDR_W-1:0]             rd_b_addr;
    logic [ELEMENT_BITS-1:0]       rd_a_data;
    logic [ELEMENT_BITS-1:0]       rd_b_data;
    logic [mmc_pkg::SUM_W-1:0]     mac_sum;
    logic                          mac_done;
    logic                          out_free;
    logic                          emit;
    logic [mmc_pkg::ROW_W-1:0]     emit_row;
    logic [mmc_pkg::COL_W-1:0]     emit_col;
    logic                          emit_last;

    logic                          r_m_valid;
    logic [mmc_pkg::ROW_W-1:0]     r_m_row;
    logic [mmc_pkg::COL_W-1:0]     r_m_col;
    logic [mmc_pkg::SUM_W-1:0]     r_m_sum;
    logic                          r_m_last;

    // Dimension registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mmc_pkg::CFG_RESET;
            r_inner_dim <= mmc_pkg::CFG_RESET;
            r_cols_b    <= mmc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mmc_pkg::REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mmc_pkg::REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mmc_pkg::REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Request decode; the block takes requests only while the sequencer is idle.
    assign s_tready  = idle;
    assign s_accept  = s_tvalid && s_tready;
    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[5:3];
    assign in_value  = $signed(s_tdata[21:6]);
    assign value_ext = VEXT_W'(in_value);
    assign in_range  = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign wr_addr   = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

    always_comb begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        start = 1'b0;
        if (s_accept) begin
            unique case (s_tuser)
                mmc_pkg::CMD_WRITE_A: we_a  = in_range;
                mmc_pkg::CMD_WRITE_B: we_b  = in_range;
                mmc_pkg::CMD_RUN:     start = 1'b1;
                default: begin
                end
            endcase
        end
    end

    mmc_store #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_we_a       (we_a),
        .i_we_b       (we_b),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (value_ext[ELEMENT_BITS-1:0]),
        .i_rd_a_addr  (rd_a_addr),
        .i_rd_b_addr  (rd_b_addr),
        .o_rd_a_data  (rd_a_data),
        .o_rd_b_data  (rd_b_data)
    );

    mmc_mac #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mac_ctl),
        .i_a          (rd_a_data),
        .i_b          (rd_b_data),
        .o_sum        (mac_sum),
        .o_done       (mac_done)
    );

    mmc_seq #(
        .MAX_DIM      (MAX_DIM),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_rows_a     (r_rows_a),
        .i_inner_dim  (r_inner_dim),
        .i_cols_b     (r_cols_b),
        .i_mac_done   (mac_done),
        .i_out_free   (out_free),
        .o_idle       (idle),
        .o_ctl        (mac_ctl),
        .o_rd_a_addr  (rd_a_addr),
        .o_rd_b_addr  (rd_b_addr),
        .o_emit       (emit),
        .o_emit_row   (emit_row),
        .o_emit_col   (emit_col),
        .o_emit_last  (emit_last)
    );

    // Output register: loads a finished element when empty or being taken.
    assign out_free = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_row  <= emit_row;
            r_m_col  <= emit_col;
            r_m_sum  <= mac_sum;
            r_m_last <= emit_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tlast  = r_m_last;
    assign m_tdata  = {(mmc_pkg::M_DATA_W - USED_W)'(0), r_m_sum, r_m_col, r_m_row};

    // No request is taken while a run is still handing out elements.
    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !s_tready)
        else $error("request accepted during a run");

endmodule

### hw/rtl/mmc_store.sv
module mmc_store #(
    parameter int MAX_DIM      = mmc_pkg::DEF_MAX_DIM,
    parameter int ELEMENT_BITS = mmc_pkg::DEF_ELEMENT_BITS,
    parameter int ADDR_W       = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                    i_clk,
    input  logic                    i_we_a,
    input  logic                    i_we_b,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic [ELEMENT_BITS-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]       i_rd_a_addr,
    input  logic [ADDR_W-1:0]       i_rd_b_addr,
    output logic [ELEMENT_BITS-1:0] o_rd_a_data,
    output logic [ELEMENT_BITS-1:0] o_rd_b_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEMENT_BITS-1:0] r_a_mem [DEPTH];
    logic [ELEMENT_BITS-1:0] r_b_mem [DEPTH];
    logic [ELEMENT_BITS-1:0] r_rd_a;
    logic [ELEMENT_BITS-1:0] r_rd_b;

    // Operand A storage, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_a_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_a_mem[i_rd_a_addr];
    end

    // Operand B storage, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we_b) begin
            r_b_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_b <= r_b_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

### hw/rtl/mmc_mac.sv
module mmc_mac #(
    parameter int ELEMENT_BITS = mmc_pkg::DEF_ELEMENT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mmc_pkg::t_mac_ctl          i_ctl,
    input  logic [ELEMENT_BITS-1:0]    i_a,
    input  logic [ELEMENT_BITS-1:0]    i_b,
    output logic [mmc_pkg::SUM_W-1:0]  o_sum,
    output logic                       o_done
);

    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int EXT_W  = (PROD_W > mmc_pkg::SUM_W) ? PROD_W : mmc_pkg::SUM_W;

    mmc_pkg::t_mac_ctl          r_ctl1;
    mmc_pkg::t_mac_ctl          r_ctl2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [EXT_W-1:0]    prod_ext;
    logic [mmc_pkg::SUM_W-1:0]  prod_term;
    logic [mmc_pkg::SUM_W-1:0]  r_acc;
    logic                       r_done;

    // Tags follow the operands: r_ctl1 matches the store read, r_ctl2 the product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    // Signed product of the two operands, registered before accumulation.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
    end

    // The sum wraps at its own width, so only its low bits are kept.
    assign prod_ext  = EXT_W'(r_prod);
    assign prod_term = prod_ext[mmc_pkg::SUM_W-1:0];

    // Accumulator restarts on the first term of each product element.
    always_ff @(posedge i_clk) begin
        if (r_ctl2.valid) begin
            if (r_ctl2.first) begin
                r_acc <= prod_term;
            end else begin
                r_acc <= r_acc + prod_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_ctl2.valid && r_ctl2.last;
        end
    end

    assign o_sum  = r_acc;
    assign o_done = r_done;

    // A finished sum always follows a valid last term.
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_ctl2.valid) && $past(r_ctl2.last))
        else $error("accumulator finished without a last term");

endmodule

### hw/rtl/mmc_seq.sv
module mmc_seq #(
    parameter int MAX_DIM = mmc_pkg::DEF_MAX_DIM,
    parameter int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mmc_pkg::CFG_W-1:0]    i_rows_a,
    input  logic [mmc_pkg::CFG_W-1:0]    i_inner_dim,
    input  logic [mmc_pkg::CFG_W-1:0]    i_cols_b,
    input  logic                         i_mac_done,
    input  logic                         i_out_free,
    output logic                         o_idle,
    output mmc_pkg::t_mac_ctl            o_ctl,
    output logic [ADDR_W-1:0]            o_rd_a_addr,
    output logic [ADDR_W-1:0]            o_rd_b_addr,
    output logic                         o_emit,
    output logic [mmc_pkg::ROW_W-1:0]    o_emit_row,
    output logic [mmc_pkg::COL_W-1:0]    o_emit_col,
    output logic                         o_emit_last
);

    localparam int DIM_W = $clog2(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_i, n_i;
    logic [DIM_W-1:0]   r_k, n_k;
    logic [DIM_W-1:0]   r_j, n_j;
    logic [DIM_W-1:0]   r_nr_m1, n_nr_m1;
    logic [DIM_W-1:0]   r_ni_m1, n_ni_m1;
    logic [DIM_W-1:0]   r_nc_m1, n_nc_m1;
    logic               last_term;
    logic               last_elem;

    // Clamp a dimension register to 1..MAX_DIM and return the top index.
    function automatic logic [DIM_W-1:0] clamp_m1(input logic [mmc_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) >= MAX_DIM) begin
            res = DIM_W'(MAX_DIM - 1);
        end else begin
            res = DIM_W'(v - mmc_pkg::CFG_W'(1));
        end
        return res;
    endfunction

    assign last_term = (r_j == r_ni_m1);
    assign last_elem = (r_i == r_nr_m1) && (r_k == r_nc_m1);

    // Sequencer: issue one term per cycle, wait for the sum, then hand it out.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        n_j     = r_j;
        n_nr_m1 = r_nr_m1;
        n_ni_m1 = r_ni_m1;
        n_nc_m1 = r_nc_m1;
        o_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_nr_m1 = clamp_m1(i_rows_a);
                    n_ni_m1 = clamp_m1(i_inner_dim);
                    n_nc_m1 = clamp_m1(i_cols_b);
                    n_i     = '0;
                    n_k     = '0;
                    n_j     = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (last_term) begin
                    n_j     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + DIM_W'(1);
                end
            end
            S_DRAIN: begin
                if (i_mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (last_elem) begin
                        n_state = S_IDLE;
                    end else if (r_k == r_nc_m1) begin
                        n_k     = '0;
                        n_i     = r_i + DIM_W'(1);
                        n_state = S_ISSUE;
                    end else begin
                        n_k     = r_k + DIM_W'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_nr_m1 <= '0;
            r_ni_m1 <= '0;
            r_nc_m1 <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_j     <= n_j;
            r_nr_m1 <= n_nr_m1;
            r_ni_m1 <= n_ni_m1;
            r_nc_m1 <= n_nc_m1;
        end
    end

    // Term tag and operand addresses for the shared multiply-accumulate.
    assign o_ctl.valid = (r_state == S_ISSUE);
    assign o_ctl.first = (r_j == '0);
    assign o_ctl.last  = last_term;

    assign o_rd_a_addr = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);
    assign o_rd_b_addr = ADDR_W'(r_j) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);

    assign o_idle      = (r_state == S_IDLE);
    assign o_emit_row  = mmc_pkg::ROW_W'(r_i);
    assign o_emit_col  = mmc_pkg::COL_W'(r_k);
    assign o_emit_last = last_elem;

    // A finished sum arrives only while the sequencer waits for it.
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mac_done |-> (r_state == S_DRAIN))
        else $error("sum finished outside the drain wait");

    // The element flagged last returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_emit_last) |=> (r_state == S_IDLE))
        else $error("run did not end after its last element");

    // A run request always starts issuing terms in the next cycle.
    a_start_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_ISSUE && r_j == '0))
        else $error("run request did not start issuing");

endmodule

### verif/matrix_multiply_core_test.sv
`timescale 1ns / 100ps

module matrix_multiply_core_test;

    localparam int MAX_DIM      = mmc_pkg::DEF_MAX_DIM;
    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD    = 300;
    // Settling wait after the last product element, scaled from MAX_DIM.
    localparam int SETTLE       = 2 * (MAX_DIM + 5);
    localparam int SMALL_PHASES = 4;
    localparam int DIRECTED_N   = 19;

    // Codes the port allows that the package leaves unnamed.
    localparam logic [mmc_pkg::CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [mmc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One product element as it should leave the block.
    typedef struct packed {
        logic [mmc_pkg::ROW_W-1:0] row;
        logic [mmc_pkg::COL_W-1:0] col;
        logic [mmc_pkg::SUM_W-1:0] sum;
        logic                      is_last;
    } t_product;

    // One directed request; typed rows carry a hand-computed 1x1 product.
    typedef struct packed {
        logic [mmc_pkg::CMD_W-1:0]   cmd;
        logic [mmc_pkg::ROW_W-1:0]   row;
        logic [mmc_pkg::COL_W-1:0]   col;
        logic [mmc_pkg::VALUE_W-1:0] value;
        logic                        typed;
        logic [mmc_pkg::SUM_W-1:0]   sum;
    } t_directed;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [mmc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mmc_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    // s_tdata: elem_row [2:0], elem_col [5:3], elem_value [21:6], zeros above.
    logic [mmc_pkg::S_DATA_W-1:0]  s_tdata;
    // s_tuser: command [1:0].
    logic [mmc_pkg::CMD_W-1:0]     s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    // m_tdata: out_row [2:0], out_col [5:3], product_sum [40:6], zeros above.
    logic [mmc_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          m_tlast;

    // Predictor state: element stores, written flags and dimension registers.
    logic signed [mmc_pkg::VALUE_W-1:0] a_elem [MAX_DIM*MAX_DIM];
    logic signed [mmc_pkg::VALUE_W-1:0] b_elem [MAX_DIM*MAX_DIM];
    bit                                 a_set  [MAX_DIM*MAX_DIM];
    bit                                 b_set  [MAX_DIM*MAX_DIM];
    logic [mmc_pkg::CFG_W-1:0]          rows_reg  = mmc_pkg::CFG_RESET;
    logic [mmc_pkg::CFG_W-1:0]          inner_reg = mmc_pkg::CFG_RESET;
    logic [mmc_pkg::CFG_W-1:0]          cols_reg  = mmc_pkg::CFG_RESET;

    t_product product_queue [$];
    int       error_count      = 0;
    int       requests_sent    = 0;
    int       runs_sent        = 0;
    int       products_checked = 0;
    int       settings_used    = 0;
    bit       steady_sender    = 1'b0;
    bit       hold_armed       = 1'b0;

    // Directed requests, all at 1x1x1: extremes, sign handling, ignored fields,
    // the unused command and writes outside the active dimensions.
    t_directed directed_reqs [DIRECTED_N] = '{
        '{mmc_pkg::CMD_WRITE_A, 3'd0, 3'd0, 16'h7fff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_WRITE_B, 3'd0, 3'd0, 16'h7fff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd0, 3'd0, 16'h0000, 1'b1, 35'h3fff_0001},
        '{mmc_pkg::CMD_WRITE_A, 3'd0, 3'd0, 16'h8000, 1'b0, 35'd0},
        '{mmc_pkg::CMD_WRITE_B, 3'd0, 3'd0, 16'h8000, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd7, 3'd7, 16'hffff, 1'b1, 35'h4000_0000},
        '{mmc_pkg::CMD_WRITE_B, 3'd0, 3'd0, 16'h7fff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd5, 3'd2, 16'h1234, 1'b0, 35'd0},
        '{mmc_pkg::CMD_WRITE_A, 3'd7, 3'd7, 16'h7fff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_WRITE_B, 3'd7, 3'd7, 16'h8000, 1'b0, 35'd0},
        '{CMD_UNUSED,           3'd0, 3'd0, 16'h1234, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
        '{mmc_pkg::CMD_WRITE_A, 3'd0, 3'd0, 16'hffff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_WRITE_B, 3'd0, 3'd0, 16'hffff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd0, 3'd0, 16'h0000, 1'b1, 35'd1},
        '{mmc_pkg::CMD_WRITE_A, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd3, 3'd4, 16'h8000, 1'b1, 35'd0},
        '{CMD_UNUSED,           3'd7, 3'd7, 16'hffff, 1'b0, 35'd0},
        '{mmc_pkg::CMD_RUN,     3'd0, 3'd0, 16'h0000, 1'b1, 35'd0}
    };

    matrix_multiply_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Effective dimension: zero counts as one, anything above the maximum saturates.
    function automatic int dim_of(input logic [mmc_pkg::CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    // Element value biased toward the Q8.8 extremes.
    function automatic logic [mmc_pkg::VALUE_W-1:0] random_element();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            default: return mmc_pkg::VALUE_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // Apply one request to the predictor; a run queues every product element.
    task automatic predict_request(input logic [mmc_pkg::CMD_W-1:0] cmd,
                                   input logic [mmc_pkg::ROW_W-1:0] row,
                                   input logic [mmc_pkg::COL_W-1:0] col,
                                   input logic [mmc_pkg::VALUE_W-1:0] value);
        int                 nr, ni, nc, i, j, k;
        logic signed [63:0] acc;
        t_product           elem;
        nr = dim_of(rows_reg);
        ni = dim_of(inner_reg);
        nc = dim_of(cols_reg);
        case (cmd)
            mmc_pkg::CMD_WRITE_A: begin
                a_elem[row * MAX_DIM + col] = value;
                a_set[row * MAX_DIM + col]  = 1'b1;
            end
            mmc_pkg::CMD_WRITE_B: begin
                b_elem[row * MAX_DIM + col] = value;
                b_set[row * MAX_DIM + col]  = 1'b1;
            end
            mmc_pkg::CMD_RUN: begin
                for (i = 0; i < nr; i++) begin
                    for (k = 0; k < nc; k++) begin
                        acc = '0;
                        for (j = 0; j < ni; j++) begin
                            acc += a_elem[i * MAX_DIM + j] * b_elem[j * MAX_DIM + k];
                        end
                        elem.row     = i[mmc_pkg::ROW_W-1:0];
                        elem.col     = k[mmc_pkg::COL_W-1:0];
                        elem.sum     = acc[mmc_pkg::SUM_W-1:0];
                        elem.is_last = (i == nr - 1) && (k == nc - 1);
                        product_queue.push_back(elem);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Offer one request after a random gap and return once it is accepted.
    task automatic send_request(input logic [mmc_pkg::CMD_W-1:0] cmd,
                                input logic [mmc_pkg::ROW_W-1:0] row,
                                input logic [mmc_pkg::COL_W-1:0] col,
                                input logic [mmc_pkg::VALUE_W-1:0] value);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(mmc_pkg::S_DATA_W - mmc_pkg::ROW_W - mmc_pkg::COL_W
                       - mmc_pkg::VALUE_W){1'b0}}, value, col, row};
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        requests_sent++;
        if (cmd == mmc_pkg::CMD_RUN) runs_sent++;
    endtask

    task automatic issue_request(input logic [mmc_pkg::CMD_W-1:0] cmd,
                                 input logic [mmc_pkg::ROW_W-1:0] row,
                                 input logic [mmc_pkg::COL_W-1:0] col,
                                 input logic [mmc_pkg::VALUE_W-1:0] value);
        send_request(cmd, row, col, value);
        predict_request(cmd, row, col, value);
    endtask

    // Stop offering, wait for every product element, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (product_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mmc_pkg::CFG_IDX_W-1:0] index,
                             input logic [mmc_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Program all three dimensions, plus a write to the unused index that must be ignored.
    task automatic set_dims(input logic [mmc_pkg::CFG_W-1:0] rows,
                            input logic [mmc_pkg::CFG_W-1:0] inner,
                            input logic [mmc_pkg::CFG_W-1:0] cols);
        write_reg(mmc_pkg::REG_ROWS_A, rows);
        write_reg(mmc_pkg::REG_INNER_DIM, inner);
        write_reg(mmc_pkg::REG_COLS_B, cols);
        write_reg(REG_UNUSED, mmc_pkg::CFG_W'($urandom_range(0, 15)));
        i_cfg_we  <= 1'b0;
        rows_reg  = rows;
        inner_reg = inner;
        cols_reg  = cols;
        settings_used++;
    endtask

    // One dimension setting: fill what a run will read, then a random mix, then a run.
    task automatic run_phase(input logic [mmc_pkg::CFG_W-1:0] rows,
                             input logic [mmc_pkg::CFG_W-1:0] inner,
                             input logic [mmc_pkg::CFG_W-1:0] cols, input int n_random);
        int                          nr, ni, nc, i, j, n, pick;
        logic [mmc_pkg::CMD_W-1:0]   cmd;
        logic [mmc_pkg::ROW_W-1:0]   row;
        logic [mmc_pkg::COL_W-1:0]   col;
        set_dims(rows, inner, cols);
        nr = dim_of(rows);
        ni = dim_of(inner);
        nc = dim_of(cols);
        steady_sender = ($urandom_range(0, 3) == 0);

        // Every element a run can read is written before the first run.
        for (i = 0; i < nr; i++) begin
            for (j = 0; j < ni; j++) begin
                if (!a_set[i * MAX_DIM + j]) begin
                    issue_request(mmc_pkg::CMD_WRITE_A, i[mmc_pkg::ROW_W-1:0],
                                  j[mmc_pkg::COL_W-1:0], random_element());
                end
            end
        end
        for (i = 0; i < ni; i++) begin
            for (j = 0; j < nc; j++) begin
                if (!b_set[i * MAX_DIM + j]) begin
                    issue_request(mmc_pkg::CMD_WRITE_B, i[mmc_pkg::ROW_W-1:0],
                                  j[mmc_pkg::COL_W-1:0], random_element());
                end
            end
        end

        // Mostly writes inside the active matrices, some outside, some noise and runs.
        for (n = 0; n < n_random; n++) begin
            pick = $urandom_range(0, 99);
            row  = mmc_pkg::ROW_W'($urandom_range(0, 7));
            col  = mmc_pkg::COL_W'($urandom_range(0, 7));
            if (pick < 40) begin
                cmd = mmc_pkg::CMD_WRITE_A;
                if ($urandom_range(0, 3) != 0) begin
                    row = mmc_pkg::ROW_W'(row % nr);
                    col = mmc_pkg::COL_W'(col % ni);
                end
            end else if (pick < 80) begin
                cmd = mmc_pkg::CMD_WRITE_B;
                if ($urandom_range(0, 3) != 0) begin
                    row = mmc_pkg::ROW_W'(row % ni);
                    col = mmc_pkg::COL_W'(col % nc);
                end
            end else if (pick < 88) begin
                cmd = CMD_UNUSED;
            end else begin
                cmd = mmc_pkg::CMD_RUN;
            end
            issue_request(cmd, row, col, random_element());
        end
        issue_request(mmc_pkg::CMD_RUN, mmc_pkg::ROW_W'($urandom_range(0, 7)),
                      mmc_pkg::COL_W'($urandom_range(0, 7)), random_element());
        wait_idle();
    endtask

    // Stimulus: reset, directed requests, then random phases over several settings.
    initial begin : stimulus
        int n;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The receiver stalls hard after the first product, while later directed
        // runs keep arriving and back up behind the full output register.
        hold_armed = 1'b1;

        // Zero in every register clamps to a 1x1x1 product.
        set_dims(4'd0, 4'd0, 4'd0);
        foreach (directed_reqs[d]) begin
            send_request(directed_reqs[d].cmd, directed_reqs[d].row, directed_reqs[d].col,
                         directed_reqs[d].value);
            if (directed_reqs[d].typed) begin
                product_queue.push_back('{3'd0, 3'd0, directed_reqs[d].sum, 1'b1});
            end else begin
                predict_request(directed_reqs[d].cmd, directed_reqs[d].row,
                                directed_reqs[d].col, directed_reqs[d].value);
            end
        end
        wait_idle();

        for (n = 0; n < SMALL_PHASES; n++) begin
            run_phase(mmc_pkg::CFG_W'($urandom_range(0, 4)),
                      mmc_pkg::CFG_W'($urandom_range(0, 4)),
                      mmc_pkg::CFG_W'($urandom_range(0, 4)), 20);
        end
        // Full size, with saturating register values on two dimensions.
        run_phase(4'd8, 4'd15, 4'd15, 12);

        $display("Sent %0d requests (%0d runs) across %0d dimension settings.",
                 requests_sent, runs_sent, settings_used);
        $display("Checked %0d product elements against predicted sums.", products_checked);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: random ready gaps, one long hold-off, and field-by-field checks.
    initial begin : product_sink
        int                         gap;
        t_product                   want;
        logic [mmc_pkg::ROW_W-1:0]  got_row;
        logic [mmc_pkg::COL_W-1:0]  got_col;
        logic [mmc_pkg::SUM_W-1:0]  got_sum;
        gap = 0;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(negedge i_clk);
            while (!m_tvalid) @(negedge i_clk);
            got_row = m_tdata[mmc_pkg::ROW_W-1:0];
            got_col = m_tdata[mmc_pkg::ROW_W+mmc_pkg::COL_W-1:mmc_pkg::ROW_W];
            got_sum = m_tdata[mmc_pkg::ROW_W+mmc_pkg::COL_W+mmc_pkg::SUM_W-1:
                              mmc_pkg::ROW_W+mmc_pkg::COL_W];
            if (product_queue.size() == 0) begin
                $error("product element (%0d,%0d) arrived with none expected", got_row, got_col);
                error_count++;
            end else begin
                want = product_queue.pop_front();
                if (got_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, got_row);
                    error_count++;
                end
                if (got_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, got_col);
                    error_count++;
                end
                if (got_sum !== want.sum) begin
                    $error("product_sum: expected %0d, got %0d",
                           $signed(want.sum), $signed(got_sum));
                    error_count++;
                end
                if (m_tlast !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, m_tlast);
                    error_count++;
                end
            end
            @(posedge i_clk);
            products_checked++;
            if (hold_armed) begin
                hold_armed = 1'b0;
                gap = LONG_HOLD;
            end else if (products_checked % 32 < 8) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 3);
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/mmc_pkg.sv
hw/rtl/mmc_store.sv
hw/rtl/mmc_mac.sv
hw/rtl/mmc_seq.sv
hw/rtl/matrix_multiply_core.sv
verif/matrix_multiply_core_test.sv
